// ----- src/lzwd_pkg.sv -----
package lzwd_pkg;

    localparam int unsigned WIN_DEPTH = 4096;
    localparam int unsigned WIN_AW    = 12;
    localparam int unsigned LOOKAHEAD = 18;
    localparam int unsigned MIN_MATCH = 3;

    localparam logic [WIN_AW-1:0] WP_START   = WIN_AW'(WIN_DEPTH - LOOKAHEAD);
    localparam logic [WIN_AW:0]   CNT_FULL   = (WIN_AW+1)'(WIN_DEPTH);
    localparam logic [7:0]        FILL_RESET = 8'h20;
    localparam logic [4:0]        REMAIN_ADJ = 5'(MIN_MATCH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REF,
        S_COPY
    } t_state;

    typedef struct packed {
        logic start_stream;
        logic load_flag;
        logic literal;
        logic save_offset;
        logic begin_copy;
        logic copy_step;
    } t_cmd;

    typedef struct packed {
        logic flag_empty;
        logic flag_bit;
        logic copy_last;
        logic out_free;
    } t_status;

endpackage

// ----- src/lzwd_in_if.sv -----
interface lzwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_req;

    modport source (output valid, output in_byte, output start_req, input ready);
    modport sink (input valid, input in_byte, input start_req, output ready);
endinterface

// ----- src/lzwd_out_if.sv -----
interface lzwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ----- src/lzwd_ctrl.sv -----
module lzwd_ctrl
    import lzwd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_start_req,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // outputs
    always_comb begin
        o_in_ready = (r_state != S_COPY) && i_status.out_free;
        w_acc      = i_in_valid && o_in_ready;
        o_cmd      = '0;
        o_cmd.start_stream = w_acc && i_start_req;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_flag   = w_acc && (i_start_req || i_status.flag_empty);
                o_cmd.literal     = w_acc && !i_start_req && !i_status.flag_empty
                                    && i_status.flag_bit;
                o_cmd.save_offset = w_acc && !i_start_req && !i_status.flag_empty
                                    && !i_status.flag_bit;
            end
            S_REF: begin
                o_cmd.load_flag  = w_acc && i_start_req;
                o_cmd.begin_copy = w_acc && !i_start_req;
            end
            S_COPY: begin
                o_cmd.copy_step = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.save_offset) begin
                    n_state = S_REF;
                end
            end
            S_REF: begin
                if (o_cmd.begin_copy) begin
                    n_state = S_COPY;
                end else if (o_cmd.load_flag) begin
                    n_state = S_IDLE;
                end
            end
            S_COPY: begin
                if (o_cmd.copy_step && i_status.copy_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/lzwd_datapath.sv -----
module lzwd_datapath
    import lzwd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic [7:0] i_in_byte,
    input  t_cmd       i_cmd,
    input  logic       i_out_ready,
    output t_status    o_status,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic [7:0]        r_mem [WIN_DEPTH];
    logic [7:0]        r_fill_byte;
    logic [7:0]        r_stream_fill;
    logic [WIN_AW-1:0] r_wp;
    logic [WIN_AW:0]   r_count;
    logic [8:0]        r_flag;
    logic [7:0]        r_offset_low;
    logic [WIN_AW-1:0] r_rd_pos;
    logic [4:0]        r_remain;
    logic [7:0]        r_rd_data;
    logic              r_rd_ok;
    logic              r_byp;
    logic [7:0]        r_byp_data;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic              w_we;
    logic [7:0]        w_wd;
    logic              w_rd_en;
    logic [WIN_AW-1:0] w_ra;
    logic [WIN_AW-1:0] w_ra_off;
    logic [7:0]        w_cur;
    logic              w_out_load;

    assign w_cur = r_byp ? r_byp_data : (r_rd_ok ? r_rd_data : r_stream_fill);
    assign w_we  = i_cmd.literal || i_cmd.copy_step;
    assign w_wd  = i_cmd.literal ? i_in_byte : w_cur;
    assign w_ra  = i_cmd.begin_copy ? {i_in_byte[7:4], r_offset_low} : r_rd_pos;
    assign w_rd_en    = i_cmd.begin_copy || (i_cmd.copy_step && (r_remain != 5'd0));
    assign w_ra_off   = w_ra - WP_START;
    assign w_out_load = w_we;

    assign o_status.flag_empty = (r_flag[8:1] == 8'd0);
    assign o_status.flag_bit   = r_flag[0];
    assign o_status.copy_last  = (r_remain == 5'd0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    // window memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wp] <= w_wd;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    // read side flags: entry written since stream start, or written this cycle
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_ok    <= ({1'b0, w_ra_off} < r_count);
            r_byp      <= w_we && (r_wp == w_ra);
            r_byp_data <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_byte   <= FILL_RESET;
            r_stream_fill <= FILL_RESET;
            r_wp          <= WP_START;
            r_count       <= '0;
            r_flag        <= '0;
            r_offset_low  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fill_byte <= i_cfg_wdata;
            end
            if (i_cmd.start_stream) begin
                r_stream_fill <= r_fill_byte;
                r_wp          <= WP_START;
                r_count       <= '0;
                r_offset_low  <= '0;
            end else if (w_we) begin
                r_wp <= r_wp + 1'b1;
                if (r_count != CNT_FULL) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.load_flag) begin
                r_flag <= {1'b1, i_in_byte};
            end else if (i_cmd.literal || i_cmd.begin_copy) begin
                r_flag <= {1'b0, r_flag[8:1]};
            end
            if (i_cmd.save_offset) begin
                r_offset_low <= i_in_byte;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // copy bookkeeping and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_copy) begin
            r_remain <= {1'b0, i_in_byte[3:0]} + REMAIN_ADJ;
        end else if (i_cmd.copy_step) begin
            r_remain <= r_remain - 1'b1;
        end
        if (w_rd_en) begin
            r_rd_pos <= w_ra + 1'b1;
        end
        if (w_out_load) begin
            r_out_byte <= w_wd;
            r_out_last <= i_cmd.literal || (r_remain == 5'd0);
        end
    end

endmodule

// ----- src/lzss_window_decoder_unit.sv -----
// LZSS decoder, 4096-byte ring window, matches of 3 to 18 bytes.
// Flag and first reference bytes produce no output.
// Literal: byte shows in the cycle after its transaction.
// Reference: after the transaction the FSM enters the copy state, where each step loads the output register,
// one byte per cycle while the output is free, set by the single write and read per cycle of the window RAM.
// Synchronous active-low reset: fill byte 32, write pointer 4078, window reads as fill.
module lzss_window_decoder_unit
    import lzwd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    lzwd_in_if.sink    i_in,
    lzwd_out_if.source o_out
);

    t_cmd    w_cmd;
    t_status w_status;

    lzwd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_start_req (i_in.start_req),
        .i_status    (w_status),
        .o_in_ready  (i_in.ready),
        .o_cmd       (w_cmd)
    );

    lzwd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_byte   (i_in.in_byte),
        .i_cmd       (w_cmd),
        .i_out_ready (o_out.ready),
        .o_status    (w_status),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.last)
    );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
    import lzwd_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned SETTLE      = 40;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } t_code;

    typedef struct {
        logic [7:0]  data;
        logic        lst;
        int unsigned tag;
    } t_plain;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = '0;

    lzwd_in_if  in_if ();
    lzwd_out_if out_if ();

    lzss_window_decoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    t_code       code_q[$];
    t_plain      plain_q[$];
    t_code       drv_item;
    t_plain      want;
    int unsigned cyc          = 0;
    int unsigned errors       = 0;
    int unsigned rx_hold_left = 0;
    bit          no_idle      = 1'b0;

    // decoder shadow state
    logic [7:0]  win [WIN_DEPTH];
    logic [11:0] wr_ptr;
    logic [8:0]  flag_bits;
    logic        ref_pending;
    logic [7:0]  ofs_lo;
    logic [7:0]  fill_val;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    function automatic void flag_error(string msg);
        errors++;
        $display("%0t: %s", $time, msg);
    endfunction

    function automatic void put_window(logic [7:0] d);
        win[wr_ptr] = d;
        wr_ptr      = wr_ptr + 1'b1;
    endfunction

    task automatic open_stream();
        for (int i = 0; i < WIN_DEPTH; i++) begin
            win[i] = fill_val;
        end
        wr_ptr      = WP_START;
        flag_bits   = '0;
        ref_pending = 1'b0;
        ofs_lo      = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic st, input int unsigned tag);
        logic [11:0] pos;
        int unsigned len;
        t_plain      p;
        if (st) begin
            open_stream();
        end
        p.tag = tag;
        if (!ref_pending) begin
            if (flag_bits <= 9'd1) begin
                flag_bits = {1'b1, b};
            end else if (flag_bits[0]) begin
                put_window(b);
                flag_bits = flag_bits >> 1;
                p.data    = b;
                p.lst     = 1'b1;
                plain_q.push_back(p);
            end else begin
                ofs_lo      = b;
                ref_pending = 1'b1;
            end
        end else begin
            pos = {b[7:4], ofs_lo};
            len = b[3:0] + MIN_MATCH;
            // copy one byte at a time so overlapping matches repeat
            for (int unsigned k = 0; k < len; k++) begin
                p.data = win[pos + 12'(k)];
                p.lst  = (k + 1 == len);
                put_window(p.data);
                plain_q.push_back(p);
            end
            flag_bits   = flag_bits >> 1;
            ref_pending = 1'b0;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                decode_byte(in_if.in_byte, in_if.start_req, cyc);
            end
            if (!in_if.valid || in_if.ready) begin
                if (code_q.size() > 0 && (no_idle || $urandom_range(99) >= 7)) begin
                    drv_item = code_q.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.in_byte   <= drv_item.data;
                    in_if.start_req <= drv_item.start;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (plain_q.size() == 0 || plain_q[0].tag >= cyc) begin
                    flag_error($sformatf("unexpected transaction: expected none, actual %02h last %0b",
                                         out_if.out_byte, out_if.last));
                end else begin
                    want = plain_q.pop_front();
                    if (out_if.out_byte !== want.data) begin
                        flag_error($sformatf("out_byte: expected %02h, actual %02h",
                                             want.data, out_if.out_byte));
                    end
                    if (out_if.last !== want.lst) begin
                        flag_error($sformatf("last: expected %0b, actual %0b",
                                             want.lst, out_if.last));
                    end
                end
            end
            out_if.ready <= rx_hold_left == 0 && (no_idle || $urandom_range(99) >= 7);
        end
    end

    function automatic void queue_code(logic [7:0] d, logic s);
        t_code c;
        c.data  = d;
        c.start = s;
        code_q.push_back(c);
    endfunction

    // one stream of 1..n flag groups; cut stops it after a first reference byte
    task automatic add_stream(input int groups, input bit cut, inout int unsigned added);
        logic [7:0]  flg;
        logic [11:0] gwp;
        logic [11:0] pos;
        logic [3:0]  lc;
        gwp = WP_START;
        for (int g = 0; g < groups; g++) begin
            flg = 8'($urandom);
            queue_code(flg, g == 0);
            added++;
            for (int k = 0; k < 8; k++) begin
                if (flg[k]) begin
                    queue_code(8'($urandom), 1'b0);
                    gwp = gwp + 1'b1;
                    added++;
                end else begin
                    pos = $urandom_range(1) ? gwp - 12'($urandom_range(1, 24)) : 12'($urandom);
                    lc  = 4'($urandom);
                    queue_code(pos[7:0], 1'b0);
                    added++;
                    if (cut && g == groups - 1) begin
                        return;
                    end
                    queue_code({pos[11:8], lc}, 1'b0);
                    added++;
                    gwp = gwp + 12'(lc) + 12'(MIN_MATCH);
                end
            end
        end
    endtask

    task automatic add_random(input int unsigned n);
        int unsigned added;
        added = 0;
        @(negedge i_clk);
        while (added < n) begin
            if ($urandom_range(9) == 0) begin
                queue_code(8'($urandom), $urandom_range(7) == 0);
                added++;
            end else begin
                add_stream($urandom_range(1, 2), $urandom_range(3) == 0, added);
            end
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (code_q.size() > 0 || in_if.valid || plain_q.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_fill(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        fill_val = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        in_if.valid     = 1'b0;
        in_if.in_byte   = '0;
        in_if.start_req = 1'b0;
        out_if.ready    = 1'b0;
        fill_val        = FILL_RESET;
        open_stream();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // new fill only applies from the next stream start
        write_fill(8'h00);
        @(negedge i_clk);
        queue_code(8'h05, 1'b0);
        queue_code(8'h00, 1'b0);
        queue_code(8'hEE, 1'b0);
        queue_code(8'hF0, 1'b0);
        queue_code(8'hFF, 1'b0);
        queue_code(8'h00, 1'b0);
        queue_code(8'h0F, 1'b0);
        queue_code(8'hFF, 1'b0);
        queue_code(8'hFF, 1'b0);
        queue_code(8'hEF, 1'b0);
        queue_code(8'hF5, 1'b0);
        queue_code(8'h12, 1'b0);
        queue_code(8'h07, 1'b1);
        queue_code(8'h80, 1'b0);
        queue_code(8'h7F, 1'b0);
        queue_code(8'h55, 1'b0);
        queue_code(8'hFE, 1'b0);
        queue_code(8'h02, 1'b0);
        queue_code(8'hF1, 1'b0);
        queue_code(8'hFE, 1'b0);
        drain();

        write_fill(8'hFF);
        add_random(30);
        drain();

        write_fill(8'($urandom));
        add_random(30);
        @(posedge i_clk);
        rx_hold_left <= HOLD_CYCLES;
        drain();

        no_idle <= 1'b1;
        write_fill(8'h5A);
        add_random(30);
        drain();
        no_idle <= 1'b0;
        repeat (SETTLE) @(posedge i_clk);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/lzwd_pkg.sv
src/lzwd_in_if.sv
src/lzwd_out_if.sv
src/lzwd_ctrl.sv
src/lzwd_datapath.sv
src/lzss_window_decoder_unit.sv
bench/tb_top.sv
